/* hw/rtl/rnsf_pkg.sv */
// Shared types, codes and constant tables of the needle strip formatter.
package rnsf_pkg;

  // Input opcodes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_DOT   = 3'd1;
  localparam logic [2:0] OP_EOL   = 3'd2;
  localparam logic [2:0] OP_TAKE  = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_BYTE     = 2'd1;
  localparam logic [1:0] ST_REFUSED  = 2'd2;
  localparam logic [1:0] ST_NOTHING  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_VQ    = 2'd0;
  localparam logic [1:0] REG_HQ    = 2'd1;
  localparam logic [1:0] REG_NMASK = 2'd2;

  localparam int unsigned SLICE_W = 24;
  localparam logic [4:0] MICROLINES = 5'd24;
  localparam logic [4:0] STRIP_FULL = 5'd22;
  localparam logic [7:0] BYTE_ESC = 8'd27;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_FF  = 8'd12;
  localparam logic [7:0] BYTE_J   = 8'd74;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_FEED, PH_GRAPH, PH_DATA, PH_FF
  } emit_phase_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_DOT_WR, CS_DATA_WR, CS_ADV, CS_SWEEP
  } ctl_state_t;

  typedef enum logic [1:0] {
    SW_CLEAR, SW_ROTATE, SW_TRIM
  } sweep_kind_t;

  // Store bit of each microline (interleaved over three slices)
  localparam logic [SLICE_W-1:0] MICRO_BIT [24] = '{
    24'h000080, 24'h008000, 24'h800000, 24'h000040, 24'h004000, 24'h400000,
    24'h000020, 24'h002000, 24'h200000, 24'h000010, 24'h001000, 24'h100000,
    24'h000008, 24'h000800, 24'h080000, 24'h000004, 24'h000400, 24'h040000,
    24'h000002, 24'h000200, 24'h020000, 24'h000001, 24'h000100, 24'h010000
  };

  function automatic logic [SLICE_W-1:0] micro_bit(input logic [4:0] n);
    logic [SLICE_W-1:0] b;
    b = '0;
    if (n < MICROLINES) begin
      b = MICRO_BIT[n];
    end
    return b;
  endfunction

  // Drop the head microline and move the rest up by one microline
  function automatic logic [SLICE_W-1:0] strip_roll(input logic [SLICE_W-1:0] a);
    return {a[6:0], 1'b0, a[23:8]};
  endfunction

  function automatic logic [7:0] header_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'd27;
      4'd1:    b = 8'd64;
      4'd2:    b = 8'd27;
      4'd3:    b = 8'd65;
      4'd4:    b = 8'd8;
      4'd5:    b = 8'd27;
      4'd6:    b = 8'd85;
      4'd7:    b = 8'd0;
      default: b = 8'd13;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] graph_byte(input logic [3:0] idx,
                                            input logic [2:0] hq,
                                            input logic [15:0] len);
    logic [7:0] b;
    logic [7:0] letter;
    case (hq)
      3'd2:    letter = 8'd89;  // Y
      3'd3:    letter = 8'd76;  // L
      3'd0,
      3'd1:    letter = 8'd75;  // K
      default: letter = 8'd90;  // Z
    endcase
    case (idx)
      4'd0:    b = 8'd27;
      4'd1:    b = 8'd85;
      4'd2:    b = 8'd48;
      4'd3:    b = 8'd27;
      4'd4:    b = 8'd115;
      4'd5:    b = 8'd48;
      4'd6:    b = 8'd27;
      4'd7:    b = letter;
      4'd8:    b = len[7:0];
      default: b = len[15:8];
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/rnsf_store.sv */
// Column store: one write port, one read port with registered read data.
module rnsf_store #(
  parameter int unsigned DEPTH = 3840,
  parameter int unsigned AW    = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              wa,
  input  logic [rnsf_pkg::SLICE_W-1:0] wd,
  input  logic [AW-1:0]              ra,
  output logic [rnsf_pkg::SLICE_W-1:0] rd
);
  import rnsf_pkg::*;

  logic [SLICE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

/* hw/rtl/raster_to_needle_strip_formatter.sv */
// Top level: command decode, byte emitter and store sweeps of the strip formatter.
//
// One command beat is taken when start is high and busy low; each beat gives exactly
// one result, strobed by out_valid for one cycle, which the receiver must take. A dot
// does a store read-modify-write; a take byte is built from the phase, or for a column
// data byte read from the store and cleared there. Rotating the strip and trimming blank
// columns each walk the whole column store, and the decision state CS_ADV picks the next
// pass after each rotation, so an end of line, end of job or the last data byte of a head
// pass can take several such passes. Start job clears the whole store, and after reset a
// clearing pass runs before the first beat is taken; configuration writes are taken at
// any time.
module raster_to_needle_strip_formatter #(
  parameter int unsigned STRIP_COLUMNS = 3840,
  parameter int unsigned FEED_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [11:0] in_column,
  input  logic        in_dot,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_job_done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import rnsf_pkg::*;

  localparam int unsigned AW = (STRIP_COLUMNS > 1) ? $clog2(STRIP_COLUMNS) : 1;
  localparam int unsigned CW = $clog2(STRIP_COLUMNS + 1);
  localparam logic [CW-1:0] NCOL = CW'(STRIP_COLUMNS);
  localparam logic [FEED_BITS-1:0] FEED_MAX = '1;

  // configuration
  logic [1:0] vq_r;
  logic [2:0] hq_r;
  logic [7:0] nmask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r    <= 2'd3;
      hq_r    <= 3'd1;
      nmask_r <= 8'hff;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VQ:    vq_r    <= cfg_data[1:0];
        REG_HQ:    hq_r    <= cfg_data[2:0];
        REG_NMASK: nmask_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // control and job state
  ctl_state_t   state_r, state_nxt;
  emit_phase_t  phase_r, phase_nxt;
  sweep_kind_t  kind_r, kind_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        plen_r, plen_nxt;
  logic [FEED_BITS-1:0] feed_r, feed_nxt;
  logic [4:0]           nml_r, nml_nxt;
  logic [4:0]           sw_r, sw_nxt;
  logic [7:0]           amask_r, amask_nxt;
  logic [2:0]           shift_r, shift_nxt;
  logic                 closing_r, closing_nxt;
  logic [SLICE_W-1:0]   pend_r, pend_nxt;
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 pv_r, pv_nxt;
  logic [AW-1:0]        pa_r, pa_nxt;
  logic [CW-1:0]        len_r, len_nxt;
  logic [AW-1:0]        col_r, col_nxt;
  logic [SLICE_W-1:0]   bit_r, bit_nxt;
  logic                 ov_r, ov_nxt;
  logic [7:0]           ob_r, ob_nxt;
  logic [1:0]           st_r, st_nxt;
  logic                 done_r, done_nxt;

  // store port
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [SLICE_W-1:0] mem_wd;
  logic [AW-1:0]      mem_ra;
  logic [SLICE_W-1:0] mem_rd;

  rnsf_store #(
    .DEPTH (STRIP_COLUMNS),
    .AW    (AW)
  ) u_store (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rd  (mem_rd)
  );

  assign busy         = (state_r != CS_IDLE);
  assign out_valid    = ov_r;
  assign out_byte     = ob_r;
  assign out_status   = st_r;
  assign out_job_done = done_r;

  // next state and outputs
  always_comb begin
    logic [7:0]           m;
    logic [2:0]           lz;
    logic [1:0]           vq;
    logic [4:0]           nml_new;
    logic [FEED_BITS-1:0] used;
    logic [CW:0]          idx_inc;
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    idx_nxt     = idx_r;
    plen_nxt    = plen_r;
    feed_nxt    = feed_r;
    nml_nxt     = nml_r;
    sw_nxt      = sw_r;
    amask_nxt   = amask_r;
    shift_nxt   = shift_r;
    closing_nxt = closing_r;
    pend_nxt    = pend_r;
    rd_idx_nxt  = rd_idx_r;
    pv_nxt      = 1'b0;
    pa_nxt      = pa_r;
    len_nxt     = len_r;
    col_nxt     = col_r;
    bit_nxt     = bit_r;
    ov_nxt      = 1'b0;
    ob_nxt      = 8'd0;
    st_nxt      = ST_ACCEPTED;
    done_nxt    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_ra      = '0;
    m           = 8'hff;
    lz          = 3'd0;
    vq          = 2'd1;
    nml_new     = 5'd0;
    used        = '0;
    idx_inc     = {1'b0, idx_r} + 1'b1;

    case (state_r)
      CS_IDLE: begin
        if (start) begin
          ov_nxt = 1'b1;
          if (in_opcode == OP_TAKE) begin
            if (phase_r == PH_IDLE) begin
              st_nxt = ST_NOTHING;
            end else begin
              st_nxt = ST_BYTE;
              case (phase_r)
                PH_HEADER: begin
                  ob_nxt = header_byte(idx_r[3:0]);
                  idx_nxt = idx_inc[CW-1:0];
                  if (idx_r[3:0] == 4'd8) begin
                    idx_nxt   = '0;
                    phase_nxt = PH_IDLE;
                  end
                end
                PH_FEED: begin
                  used = (feed_r > FEED_BITS'(255)) ? FEED_BITS'(255) : feed_r;
                  case (idx_r[1:0])
                    2'd0:    ob_nxt = BYTE_ESC;
                    2'd1:    ob_nxt = BYTE_J;
                    2'd2:    ob_nxt = used[7:0];
                    default: ob_nxt = BYTE_CR;
                  endcase
                  idx_nxt = idx_inc[CW-1:0];
                  if (idx_r[1:0] == 2'd3) begin
                    idx_nxt  = '0;
                    feed_nxt = feed_r - used;
                    if (feed_r == used) begin
                      phase_nxt = PH_GRAPH;
                    end
                  end
                end
                PH_GRAPH: begin
                  ob_nxt  = graph_byte(idx_r[3:0], hq_r, 16'(plen_r));
                  idx_nxt = idx_inc[CW-1:0];
                  if (idx_r[3:0] == 4'd9) begin
                    idx_nxt = '0;
                    if (plen_r == '0) begin
                      // empty head pass: drop the slice and go on
                      pend_nxt   = pend_r & ~{16'd0, amask_r};
                      kind_nxt   = SW_ROTATE;
                      rd_idx_nxt = '0;
                      state_nxt  = CS_SWEEP;
                    end else begin
                      phase_nxt = PH_DATA;
                    end
                  end
                end
                PH_DATA: begin
                  // byte comes from the store next cycle
                  ov_nxt    = 1'b0;
                  mem_ra    = idx_r[AW-1:0];
                  state_nxt = CS_DATA_WR;
                end
                default: begin
                  ob_nxt      = BYTE_FF;
                  done_nxt    = 1'b1;
                  closing_nxt = 1'b0;
                  idx_nxt     = '0;
                  phase_nxt   = PH_IDLE;
                end
              endcase
            end
          end else if (in_opcode > OP_END) begin
            st_nxt = ST_NOTHING;
          end else if (phase_r != PH_IDLE) begin
            st_nxt = ST_REFUSED;
          end else if (in_opcode == OP_START) begin
            m = (nmask_r == 8'd0) ? 8'hff : nmask_r;
            for (int i = 0; i < 8; i++) begin
              if (m[i]) begin
                lz = 3'(7 - i);
              end
            end
            shift_nxt   = lz;
            amask_nxt   = m << lz;
            pend_nxt    = '0;
            feed_nxt    = '0;
            nml_nxt     = '0;
            sw_nxt      = '0;
            closing_nxt = 1'b0;
            idx_nxt     = '0;
            phase_nxt   = PH_HEADER;
            kind_nxt    = SW_CLEAR;
            rd_idx_nxt  = '0;
            state_nxt   = CS_SWEEP;
          end else if (in_opcode == OP_DOT) begin
            if (in_dot && ({1'b0, in_column} < 13'(STRIP_COLUMNS)) && nml_r < MICROLINES) begin
              bit_nxt   = micro_bit(nml_r);
              pend_nxt  = pend_r | micro_bit(nml_r);
              col_nxt   = in_column[AW-1:0];
              mem_ra    = in_column[AW-1:0];
              state_nxt = CS_DOT_WR;
            end
          end else if (in_opcode == OP_EOL) begin
            vq        = (vq_r == 2'd0) ? 2'd1 : vq_r;
            nml_new   = nml_r + 5'(3'd4 - {1'b0, vq});
            nml_nxt   = nml_new;
            sw_nxt    = (nml_new >= STRIP_FULL) ? nml_new - 5'd21 : 5'd0;
            state_nxt = CS_ADV;
          end else begin
            closing_nxt = 1'b1;
            sw_nxt      = nml_r;
            state_nxt   = CS_ADV;
          end
        end
      end

      CS_DOT_WR: begin
        mem_we    = 1'b1;
        mem_wa    = col_r;
        mem_wd    = mem_rd | bit_r;
        state_nxt = CS_IDLE;
      end

      CS_DATA_WR: begin
        ov_nxt    = 1'b1;
        st_nxt    = ST_BYTE;
        ob_nxt    = mem_rd[7:0] >> shift_r;
        mem_we    = 1'b1;
        mem_wa    = idx_r[AW-1:0];
        mem_wd    = mem_rd & ~{16'd0, amask_r};
        idx_nxt   = idx_inc[CW-1:0];
        state_nxt = CS_IDLE;
        if (idx_inc >= {1'b0, plen_r}) begin
          pend_nxt   = pend_r & ~{16'd0, amask_r};
          kind_nxt   = SW_ROTATE;
          rd_idx_nxt = '0;
          state_nxt  = CS_SWEEP;
        end
      end

      CS_ADV: begin
        rd_idx_nxt = '0;
        if (sw_r == 5'd0) begin
          idx_nxt   = '0;
          phase_nxt = closing_r ? PH_FF : PH_IDLE;
          state_nxt = CS_IDLE;
        end else if (pend_r[7]) begin
          kind_nxt  = SW_TRIM;
          len_nxt   = '0;
          state_nxt = CS_SWEEP;
        end else begin
          kind_nxt  = SW_ROTATE;
          state_nxt = CS_SWEEP;
        end
      end

      CS_SWEEP: begin
        if (kind_r == SW_CLEAR) begin
          // one entry a cycle, no read needed
          if (rd_idx_r == NCOL) begin
            state_nxt = CS_IDLE;
          end else begin
            mem_we     = 1'b1;
            mem_wa     = rd_idx_r[AW-1:0];
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end else begin
          // read ahead one entry, act on the entry read last cycle
          if (rd_idx_r != NCOL) begin
            mem_ra     = rd_idx_r[AW-1:0];
            pv_nxt     = 1'b1;
            pa_nxt     = rd_idx_r[AW-1:0];
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
          if (pv_r) begin
            if (kind_r == SW_ROTATE) begin
              mem_we = 1'b1;
              mem_wa = pa_r;
              mem_wd = strip_roll(mem_rd);
            end else if ((mem_rd[7:0] & amask_r) != 8'd0) begin
              len_nxt = CW'(pa_r) + 1'b1;
            end
          end
          if (rd_idx_r == NCOL && !pv_r) begin
            if (kind_r == SW_ROTATE) begin
              pend_nxt  = strip_roll(pend_r);
              feed_nxt  = (feed_r != FEED_MAX) ? feed_r + 1'b1 : feed_r;
              nml_nxt   = (nml_r != 5'd0) ? nml_r - 5'd1 : nml_r;
              sw_nxt    = (sw_r != 5'd0) ? sw_r - 5'd1 : sw_r;
              state_nxt = CS_ADV;
            end else begin
              plen_nxt  = len_r;
              idx_nxt   = '0;
              phase_nxt = (feed_r != '0) ? PH_FEED : PH_GRAPH;
              state_nxt = CS_IDLE;
            end
          end
        end
      end

      default: state_nxt = CS_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= CS_SWEEP;
      kind_r    <= SW_CLEAR;
      rd_idx_r  <= '0;
      pv_r      <= 1'b0;
      phase_r   <= PH_IDLE;
      idx_r     <= '0;
      plen_r    <= '0;
      feed_r    <= '0;
      nml_r     <= '0;
      sw_r      <= '0;
      amask_r   <= 8'hff;
      shift_r   <= 3'd0;
      closing_r <= 1'b0;
      pend_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      kind_r    <= kind_nxt;
      rd_idx_r  <= rd_idx_nxt;
      pv_r      <= pv_nxt;
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      plen_r    <= plen_nxt;
      feed_r    <= feed_nxt;
      nml_r     <= nml_nxt;
      sw_r      <= sw_nxt;
      amask_r   <= amask_nxt;
      shift_r   <= shift_nxt;
      closing_r <= closing_nxt;
      pend_r    <= pend_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pa_r   <= pa_nxt;
    len_r  <= len_nxt;
    col_r  <= col_nxt;
    bit_r  <= bit_nxt;
    ob_r   <= ob_nxt;
    st_r   <= st_nxt;
    done_r <= done_nxt;
  end

endmodule
